// ----- sv/slsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsm_pkg
// Shared types, codes and the fixed-point blend used by the velocity smoother.
// ----------------------------------------------------------------------------
package slsm_pkg;

	// Item commands carried in the input tuser field.
	typedef enum logic [1:0] {
		CMD_STEP   = 2'd0,
		CMD_FILTER = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACCEL  = 2'd0;
	localparam logic [1:0] REG_DECEL  = 2'd1;
	localparam logic [1:0] REG_VCOEFF = 2'd2;
	localparam logic [1:0] REG_OCOEFF = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] ACCEL_RST  = 16'd7680;
	localparam logic [15:0] DECEL_RST  = 16'd15360;
	localparam logic [8:0]  VCOEFF_RST = 9'd102;
	localparam logic [8:0]  OCOEFF_RST = 9'd154;

	// Unity weight in Q1.8 and the small-error threshold in Q8.8.
	localparam logic [8:0]         COEFF_ONE = 9'd256;
	localparam logic signed [16:0] SMALL_ERR = 17'sd26;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the accepted item
		logic mul;    // select rate and form rate * dt
		logic spd;    // clamp the error and update the present speed
		logic lp1;    // first blend stage
		logic lp2;    // second blend stage into the filtered value
		logic clr;    // clear both state entries
		logic emit;   // load the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t in_cmd;
		logic in_dt_zero;
	} dp_stat_t;

	// Weighted blend floor((c*x + (256-c)*p) / 256), saturated to 16 bits.
	function automatic logic signed [15:0] lp_blend(
		input logic signed [15:0] x,
		input logic signed [15:0] p,
		input logic [8:0]         c
	);
		logic [8:0]         cc;
		logic signed [9:0]  ca;
		logic signed [9:0]  cb;
		logic signed [26:0] s;
		logic signed [18:0] q;
		logic signed [15:0] r;
		cc = (c > COEFF_ONE) ? COEFF_ONE : c;
		ca = $signed({1'b0, cc});
		cb = 10'sd256 - ca;
		s  = (27'(ca) * 27'(x)) + (27'(cb) * 27'(p));
		q  = 19'(s >>> 8);
		if (q > 19'sd32767) begin
			r = 16'sh7FFF;
		end else if (q < -19'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(q);
		end
		return r;
	endfunction

endpackage

// ----- sv/slsm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsm_ctrl
// Sequencer for one item at a time: decodes the command, steps the datapath
// through the slew and blend stages and owns the output valid flag.
// ----------------------------------------------------------------------------
module slsm_ctrl
	import slsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LIM  = 7'b0000010,
		ST_SPD  = 7'b0000100,
		ST_LP1  = 7'b0001000,
		ST_LP2  = 7'b0010000,
		ST_CLR  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (stat.in_cmd)
						CMD_STEP:   state_d = stat.in_dt_zero ? ST_EMIT : ST_LIM;
						CMD_FILTER: state_d = ST_LP2;
						CMD_CLEAR:  state_d = ST_CLR;
						CMD_NOP:    state_d = ST_EMIT;
						default:    state_d = ST_EMIT;
					endcase
				end
			end
			ST_LIM: begin
				cmd.mul = 1'b1;
				state_d = ST_SPD;
			end
			ST_SPD: begin
				cmd.spd = 1'b1;
				state_d = ST_LP1;
			end
			ST_LP1: begin
				cmd.lp1 = 1'b1;
				state_d = ST_LP2;
			end
			ST_LP2: begin
				cmd.lp2 = 1'b1;
				state_d = ST_EMIT;
			end
			ST_CLR: begin
				cmd.clr = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/slsm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsm_datapath
// Configuration registers, velocity state, rate multiplier, slew clamp,
// shared blend unit and the output register.
// ----------------------------------------------------------------------------
module slsm_datapath
	import slsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         in_user,
	input  logic [47:0]        in_data,
	output logic signed [15:0] out_data,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat
);

	// Configuration.
	logic [15:0] accel_q, decel_q;
	logic [8:0]  vcoef_q, ocoef_q;

	// State.
	logic signed [15:0] present_q, filt_q;

	// Item and intermediate registers.
	cmd_t               cmd_q;
	logic signed [15:0] tgt_q, ext_q, fv_q, out_q;
	logic [15:0]        dt_q;
	logic [15:0]        prod_q;   // rate * dt, scaled down by 2^16
	logic               half_q;
	logic signed [16:0] err_q;

	logic signed [16:0] err;
	logic               small_err, same_dir;
	logic [15:0]        rate;
	logic [15:0]        lim;
	logic signed [17:0] lim_s, err_x, chg, sum;
	logic signed [15:0] spd_new;
	logic signed [15:0] bl_x, bl_y;
	logic [8:0]         bl_c;

	assign stat.in_cmd     = cmd_t'(in_user);
	assign stat.in_dt_zero = (in_data[31:16] == 16'd0);
	assign out_data        = out_q;

	// Rate selection from the speed error.
	always_comb begin
		err       = 17'(tgt_q) - 17'(present_q);
		small_err = (err < SMALL_ERR) && (err > -SMALL_ERR);
		same_dir  = ((err > 17'sd0) && (present_q >= 16'sd0)) ||
		            ((err < 17'sd0) && (present_q <= 16'sd0));
		if (small_err) begin
			rate = (accel_q < decel_q) ? accel_q : decel_q;
		end else begin
			rate = same_dir ? accel_q : decel_q;
		end
	end

	// Clamp the error to the limit and saturate the new speed.
	always_comb begin
		lim   = half_q ? {1'b0, prod_q[15:1]} : prod_q;
		lim_s = $signed({2'b00, lim});
		err_x = 18'(err_q);
		if (err_x > lim_s) begin
			chg = lim_s;
		end else if (err_x < -lim_s) begin
			chg = -lim_s;
		end else begin
			chg = err_x;
		end
		sum = 18'(present_q) + chg;
		if (sum > 18'sd32767) begin
			spd_new = 16'sh7FFF;
		end else if (sum < -18'sd32768) begin
			spd_new = 16'sh8000;
		end else begin
			spd_new = 16'(sum);
		end
	end

	// Shared blend unit, operands chosen by stage.
	always_comb begin
		if (cmd.lp1) begin
			bl_x = present_q;
			bl_c = vcoef_q;
		end else begin
			bl_x = (cmd_q == CMD_FILTER) ? ext_q : fv_q;
			bl_c = ocoef_q;
		end
		bl_y = lp_blend(bl_x, filt_q, bl_c);
	end

	// Configuration and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q   <= ACCEL_RST;
			decel_q   <= DECEL_RST;
			vcoef_q   <= VCOEFF_RST;
			ocoef_q   <= OCOEFF_RST;
			present_q <= '0;
			filt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACCEL:  accel_q <= cfg_data;
					REG_DECEL:  decel_q <= cfg_data;
					REG_VCOEFF: vcoef_q <= cfg_data[8:0];
					REG_OCOEFF: ocoef_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (cmd.clr) begin
				present_q <= '0;
				filt_q    <= '0;
			end else begin
				if (cmd.spd) begin
					present_q <= spd_new;
				end
				if (cmd.lp2) begin
					filt_q <= bl_y;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= cmd_t'(in_user);
			tgt_q <= $signed(in_data[15:0]);
			dt_q  <= in_data[31:16];
			ext_q <= $signed(in_data[47:32]);
		end
		if (cmd.mul) begin
			prod_q <= 16'((32'(rate) * 32'(dt_q)) >> 16);
			half_q <= small_err;
			err_q  <= err;
		end
		if (cmd.lp1) begin
			fv_q <= bl_y;
		end
		if (cmd.emit) begin
			out_q <= filt_q;
		end
	end

endmodule

// ----- sv/slew_limited_velocity_smoother.sv -----
`timescale 1ns / 1ps
// Sequence: a slew step passes the LIM, SPD, LP1, LP2 and EMIT states before it
// is in the output register; filter and clear items pass LP2 or CLR, then EMIT;
// a zero time step or no-op goes straight to EMIT, which holds on output stall.
// One item at a time: a step uses the rate multiplier, then two blend passes.
// Reset: arst_n clears speed and filtered output and restores register defaults.
// ----------------------------------------------------------------------------
// slew_limited_velocity_smoother
// Slew-rate limited velocity with a two-stage first-order low-pass output.
// ----------------------------------------------------------------------------
module slew_limited_velocity_smoother
	import slsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // target_speed, time_step, external_value
	input  logic [1:0]  s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // smoothed_output
);

	dp_cmd_t            dcmd;
	dp_stat_t           dstat;
	logic signed [15:0] out_data;

	// Register writes are always taken.
	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = out_data;

	slsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (dstat),
		.cmd       (dcmd)
	);

	slsm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_data  (out_data),
		.cmd       (dcmd),
		.stat      (dstat)
	);

endmodule

// ----- sv/slsm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsm_checker
// Port-level checks on the velocity smoother, bound to the top level.
// ----------------------------------------------------------------------------
module slsm_checker
	import slsm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// Only one item is in flight, so an input transfer is never followed at once.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken again while an item is in flight");

	// Register writes are never stalled.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// A clear with a free output shows a zero result once it has passed CLR and EMIT.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_CLEAR) && !m_axis_tvalid)
		|-> ##3 (m_axis_tvalid && (m_axis_tdata == 16'd0)))
		else $error("clear did not produce a zero result");

endmodule

bind slew_limited_velocity_smoother slsm_checker u_slsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
